>>> sv/isp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isp_pkg
// Shared types, codes and decode tables of the stream parser.
// ----------------------------------------------------------------------------
package isp_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_TYPE  = 3'd1,
        PH_NDIMS = 3'd2,
        PH_DIMS  = 3'd3,
        PH_BODY  = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERROR = 3'd6
    } phase_t;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_DIM     = 2'd1;
    localparam logic [1:0] KIND_ELEMENT = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_MAGIC     = 2'd0;
    localparam logic [1:0] ERR_TYPE      = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    localparam logic [2:0] TC_UINT8  = 3'd0;
    localparam logic [2:0] TC_INT8   = 3'd1;
    localparam logic [2:0] TC_INT16  = 3'd2;
    localparam logic [2:0] TC_INT32  = 3'd3;
    localparam logic [2:0] TC_FLOAT  = 3'd4;
    localparam logic [2:0] TC_DOUBLE = 3'd5;

    localparam logic [7:0] TB_UINT8  = 8'h08;
    localparam logic [7:0] TB_INT8   = 8'h09;
    localparam logic [7:0] TB_INT16  = 8'h0B;
    localparam logic [7:0] TB_INT32  = 8'h0C;
    localparam logic [7:0] TB_FLOAT  = 8'h0D;
    localparam logic [7:0] TB_DOUBLE = 8'h0E;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic [7:0]  dim_index;
        logic [2:0]  type_code;
        logic [1:0]  error_code;
        logic        final_element;
        logic        last_in_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] code;
    } type_decode_t;

    function automatic type_decode_t decode_type(input logic [7:0] b);
        type_decode_t d;
        d.ok = 1'b1;
        unique case (b)
            TB_UINT8:  d.code = TC_UINT8;
            TB_INT8:   d.code = TC_INT8;
            TB_INT16:  d.code = TC_INT16;
            TB_INT32:  d.code = TC_INT32;
            TB_FLOAT:  d.code = TC_FLOAT;
            TB_DOUBLE: d.code = TC_DOUBLE;
            default:
            begin
                d.ok   = 1'b0;
                d.code = TC_UINT8;
            end
        endcase
        return d;
    endfunction

    function automatic logic [3:0] elem_width(input logic [2:0] code);
        logic [3:0] w;
        unique case (code)
            TC_INT16:  w = 4'd2;
            TC_INT32:  w = 4'd4;
            TC_FLOAT:  w = 4'd4;
            TC_DOUBLE: w = 4'd8;
            default:   w = 4'd1;
        endcase
        return w;
    endfunction

    function automatic result_t error_result(input logic [1:0] code);
        result_t r;
        r.kind          = KIND_ERROR;
        r.value         = 64'd0;
        r.dim_index     = 8'd0;
        r.type_code     = 3'd0;
        r.error_code    = code;
        r.final_element = 1'b0;
        r.last_in_run   = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/isp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isp_front
// Byte classifier: header phases, dimension product, element assembly.
// ----------------------------------------------------------------------------
module isp_front #(
    parameter int COUNT_BITS = 48
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_file,
    output isp_pkg::push_t     push
);
    import isp_pkg::*;

    localparam int PROD_BITS = COUNT_BITS + 32;

    phase_t                  phase_reg, phase_next, phase_step;
    logic [2:0]              byte_pos_reg, byte_pos_next;
    logic [7:0]              dims_total_reg, dims_total_next;
    logic [7:0]              dim_counter_reg, dim_counter_next;
    logic [2:0]              elem_type_reg, elem_type_next;
    logic [63:0]             assembly_reg, assembly_next;
    logic [COUNT_BITS-1:0]   left_reg, left_next;
    logic [PROD_BITS-1:0]    product_reg, product_next;

    logic                    accept;
    logic [COUNT_BITS+7:0]   mult;
    logic [PROD_BITS-1:0]    prod_new;
    logic                    overflow;
    logic                    dim_last;
    logic [31:0]             dim_len;
    logic [63:0]             body_asm;
    logic                    elem_last;
    logic [COUNT_BITS-1:0]   left_dec;
    logic                    fin;
    logic [7:0]              dim_count_inc;
    type_decode_t            tdec;

    assign accept        = in_valid && !in_stall;
    assign mult          = {8'd0, left_reg} * {{COUNT_BITS{1'b0}}, data_byte};
    assign prod_new      = {product_reg[PROD_BITS-9:0], 8'h00} + {24'd0, mult};
    assign overflow      = |prod_new[PROD_BITS-1:COUNT_BITS];
    assign dim_last      = byte_pos_reg >= 3'd3;
    assign dim_len       = {assembly_reg[23:0], data_byte};
    assign body_asm      = {assembly_reg[55:0], data_byte};
    assign elem_last     = ({1'b0, byte_pos_reg} + 4'd1) >= elem_width(elem_type_reg);
    assign left_dec      = left_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign fin           = left_dec == '0;
    assign dim_count_inc = dim_counter_reg + 8'd1;
    assign tdec          = decode_type(data_byte);

    always_comb
    begin
        phase_step       = phase_reg;
        byte_pos_next    = byte_pos_reg;
        dims_total_next  = dims_total_reg;
        dim_counter_next = dim_counter_reg;
        elem_type_next   = elem_type_reg;
        assembly_next    = assembly_reg;
        left_next        = left_reg;
        product_next     = product_reg;
        unique case (phase_reg)
            PH_MAGIC:
            begin
                if (data_byte != 8'd0)
                begin
                    phase_step = PH_ERROR;
                end
                else if (byte_pos_reg != 3'd0)
                begin
                    byte_pos_next = 3'd0;
                    phase_step    = PH_TYPE;
                end
                else
                begin
                    byte_pos_next = 3'd1;
                end
            end
            PH_TYPE:
            begin
                elem_type_next = tdec.code;
                phase_step     = tdec.ok ? PH_NDIMS : PH_ERROR;
            end
            PH_NDIMS:
            begin
                dims_total_next  = data_byte;
                dim_counter_next = 8'd0;
                left_next        = {{(COUNT_BITS-1){1'b0}}, 1'b1};
                assembly_next    = 64'd0;
                byte_pos_next    = 3'd0;
                product_next     = '0;
                phase_step       = (data_byte == 8'd0) ? PH_BODY : PH_DIMS;
            end
            PH_DIMS:
            begin
                assembly_next = {32'd0, dim_len};
                product_next  = prod_new;
                if (dim_last)
                begin
                    if (overflow)
                    begin
                        phase_step = PH_ERROR;
                    end
                    else
                    begin
                        left_next        = prod_new[COUNT_BITS-1:0];
                        dim_counter_next = dim_count_inc;
                        assembly_next    = 64'd0;
                        byte_pos_next    = 3'd0;
                        product_next     = '0;
                        if (dim_count_inc == dims_total_reg)
                        begin
                            phase_step = (prod_new[COUNT_BITS-1:0] == '0) ? PH_DONE : PH_BODY;
                        end
                    end
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 3'd1;
                end
            end
            PH_BODY:
            begin
                assembly_next = body_asm;
                if (elem_last)
                begin
                    left_next     = left_dec;
                    assembly_next = 64'd0;
                    byte_pos_next = 3'd0;
                    if (fin)
                    begin
                        phase_step = PH_DONE;
                    end
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 3'd1;
                end
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase
        phase_next = end_of_file ? PH_MAGIC : phase_step;
    end

    always_comb
    begin
        result_t main_r, extra_r;
        logic    main_v, extra_v;
        main_v  = 1'b0;
        extra_v = 1'b0;
        main_r  = error_result(ERR_MAGIC);
        extra_r = error_result(ERR_TRUNCATED);
        unique case (phase_reg)
            PH_MAGIC:
            begin
                main_v = data_byte != 8'd0;
            end
            PH_TYPE:
            begin
                main_v = !tdec.ok;
                main_r = error_result(ERR_TYPE);
            end
            PH_NDIMS:
            begin
                main_v           = 1'b1;
                main_r.kind      = KIND_HEADER;
                main_r.value     = {56'd0, data_byte};
                main_r.type_code = elem_type_reg;
            end
            PH_DIMS:
            begin
                main_v           = dim_last;
                main_r.kind      = KIND_DIM;
                main_r.value     = {32'd0, dim_len};
                main_r.dim_index = dim_counter_reg;
                main_r.type_code = elem_type_reg;
                if (dim_last && overflow)
                begin
                    extra_v = 1'b1;
                    extra_r = error_result(ERR_OVERFLOW);
                end
            end
            PH_BODY:
            begin
                main_v               = elem_last;
                main_r.kind          = KIND_ELEMENT;
                main_r.value         = body_asm;
                main_r.type_code     = elem_type_reg;
                main_r.final_element = fin;
            end
            default:
            begin
                main_v = 1'b0;
            end
        endcase
        if (end_of_file && phase_step != PH_DONE && phase_step != PH_ERROR)
        begin
            extra_v = 1'b1;
            extra_r = error_result(ERR_TRUNCATED);
        end
        extra_r.last_in_run = 1'b1;
        main_r.last_in_run  = !extra_v;
        push.first  = main_v ? main_r : extra_r;
        push.second = extra_r;
        if (!accept)
        begin
            push.count = 2'd0;
        end
        else
        begin
            push.count = {1'b0, main_v} + {1'b0, extra_v};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MAGIC;
            byte_pos_reg    <= 3'd0;
            dims_total_reg  <= 8'd0;
            dim_counter_reg <= 8'd0;
            elem_type_reg   <= 3'd0;
            assembly_reg    <= 64'd0;
            left_reg        <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
            product_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            if (end_of_file)
            begin
                byte_pos_reg    <= 3'd0;
                dims_total_reg  <= 8'd0;
                dim_counter_reg <= 8'd0;
                elem_type_reg   <= 3'd0;
                assembly_reg    <= 64'd0;
                left_reg        <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
                product_reg     <= '0;
            end
            else
            begin
                byte_pos_reg    <= byte_pos_next;
                dims_total_reg  <= dims_total_next;
                dim_counter_reg <= dim_counter_next;
                elem_type_reg   <= elem_type_next;
                assembly_reg    <= assembly_next;
                left_reg        <= left_next;
                product_reg     <= product_next;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/isp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isp_queue
// Result queue between classifier and output stage, two pushes, one pop.
// ----------------------------------------------------------------------------
module isp_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire isp_pkg::push_t push,
    input  wire logic          pop,
    output logic               head_valid,
    output isp_pkg::result_t   head,
    output logic               full
);
    import isp_pkg::*;

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic [QPTR_BITS-1:0]   wr_ptr_inc;
    logic                   do_pop;

    assign head_valid  = count_reg != '0;
    assign head        = entry_reg[rd_ptr_reg];
    assign full        = count_reg > QCNT_BITS'(QUEUE_DEPTH - 2);
    assign do_pop      = pop && head_valid;
    assign wr_ptr_inc  = wr_ptr_reg + QPTR_BITS'(1);
    assign wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QPTR_BITS'(do_pop);
    assign count_next  = count_reg + QCNT_BITS'(push.count) - QCNT_BITS'(do_pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2))
        else $error("push into queue without room for two entries");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == QCNT_BITS'($past(count_reg) + QCNT_BITS'($past(push.count))
                                         - QCNT_BITS'($past(do_pop))))
        else $error("queue count does not follow pushes and pops");

    a_two_implies_one: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd3)
        else $error("more than two results from one beat");

endmodule
`default_nettype wire

>>> sv/isp_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isp_out_stage
// Output register: takes the queue head when empty or when its beat leaves.
// ----------------------------------------------------------------------------
module isp_out_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire isp_pkg::result_t head,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output isp_pkg::result_t   out_data
);
    import isp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign pop        = head_valid && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/idx_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idx_stream_parser
// Byte-serial IDX parser: header check, dimension product, element output.
// ----------------------------------------------------------------------------
// path: a result is registered in the queue and then in the output reg after its byte beat
// throughput: one byte per cycle while in_stall is low; results leave one per
//   cycle while out_stall is low, via the single-read queue; a second result waits
// in_stall rises while the queue holds more than two results
// reset: asynchronous, parser back to the magic bytes, queue and output empty
module idx_stream_parser #(
    parameter int COUNT_BITS = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_file,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       result_kind,
    output logic [63:0]      value,
    output logic [7:0]       dim_index,
    output logic [2:0]       type_code,
    output logic [1:0]       error_code,
    output logic             final_element,
    output logic             last_in_run
);
    import isp_pkg::*;

    push_t   push;
    logic    head_valid;
    result_t head;
    logic    pop;
    result_t out_data;

    isp_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .push        (push)
    );

    isp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (in_stall)
    );

    isp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign result_kind   = out_data.kind;
    assign value         = out_data.value;
    assign dim_index     = out_data.dim_index;
    assign type_code     = out_data.type_code;
    assign error_code    = out_data.error_code;
    assign final_element = out_data.final_element;
    assign last_in_run   = out_data.last_in_run;

endmodule
`default_nettype wire
